>>> rtl/periodic_stream_frame_scheduler_assert.svh
// Assertion macros shared by the scheduler checker.
// No dependencies.
`ifndef PERIODIC_STREAM_FRAME_SCHEDULER_ASSERT_SVH
`define PERIODIC_STREAM_FRAME_SCHEDULER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PSFS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle implication checked outside reset.
`define PSFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/psfs_pkg.sv
// Shared types and constants of the periodic stream frame scheduler.
// No dependencies.
package psfs_pkg;
    localparam int STREAM_SLOTS = 8;
    localparam int QUEUE_DEPTH  = 16;
    localparam int SLOT_W  = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = 88;
    localparam int IN_W    = 120;
    localparam int OUT_W   = 104;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_STOP  = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_DEQ   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_DIV  = 3'd1,
        ST_DUP_ID   = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOT_FND  = 3'd4,
        ST_Q_EMPTY  = 3'd5
    } t_status;
endpackage

>>> rtl/periodic_stream_frame_scheduler.sv
// Periodic stream frame scheduler: one request in, one result out.
// Uses psfs_pkg and two psfs_ram banks for the frame queue.
//
// Input request (s side): mode, strm_id, divider, loop_count, timestamp.
// Result (m side): status, frame fields, frames_added, queue_level.
// One result per request, in request order.
// A stop reads each queued frame once; a tick checks every slot in turn.
// A due stream runs a shared serial remainder unit, one bit per cycle over
// the 32-bit lag behind its due count; this unit sets the tick time.
// One request is in work at a time; o_s_tready is high only when idle.
// The result register holds one finished result, so a new request is taken
// while it waits; a second result waits inside until the receiver takes it.
// Reset empties the stream table and the queue and drops a pending result.
// A hit stop compacts the queue from one RAM bank into the other and swaps.
module periodic_stream_frame_scheduler (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // mode[1:0], strm_id[9:2], divider[17:10], loop_count[49:18],
    // timestamp[113:50], zero fill
    input  logic [psfs_pkg::IN_W-1:0]  i_s_tdata,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // status[2:0], frame_stream[10:3], frame_sequence[26:11],
    // frame_time[90:27], frames_added[94:91], queue_level[99:95], zero fill
    output logic [psfs_pkg::OUT_W-1:0] o_m_tdata
);
    localparam int SW = psfs_pkg::SLOT_W;
    localparam int PW = psfs_pkg::QPTR_W;
    localparam int CW = psfs_pkg::QCNT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_CMP_RD, S_CMP_WR, S_TK_CHK, S_TK_DIV, S_TK_PUSH, S_DQ_WAIT, S_FIN
    } t_state;

    t_state r_state;

    logic        r_active  [psfs_pkg::STREAM_SLOTS];
    logic [7:0]  r_sl_id   [psfs_pkg::STREAM_SLOTS];
    logic [7:0]  r_sl_div  [psfs_pkg::STREAM_SLOTS];
    logic [31:0] r_sl_due  [psfs_pkg::STREAM_SLOTS];
    logic [15:0] r_sl_seq  [psfs_pkg::STREAM_SLOTS];

    logic [PW-1:0] r_head, r_tail, r_rd;
    logic [CW-1:0] r_count, r_i, r_kept;
    logic          r_bank;

    logic [7:0]    r_sid;
    logic [31:0]   r_loop;
    logic [63:0]   r_ts;
    logic [SW-1:0] r_slot;
    logic [31:0]   r_dvd;
    logic [7:0]    r_rem;
    logic [4:0]    r_bit;

    logic [2:0]    r_status;
    logic [7:0]    r_fstream;
    logic [15:0]   r_fseq;
    logic [63:0]   r_ftime;
    logic [3:0]    r_added;

    logic                      r_ovalid;
    logic [psfs_pkg::OUT_W-1:0] r_odata;

    logic [1:0]  in_mode;
    logic [7:0]  in_sid, in_div;
    logic [31:0] in_loop;
    logic [63:0] in_ts;
    assign in_mode = i_s_tdata[1:0];
    assign in_sid  = i_s_tdata[9:2];
    assign in_div  = i_s_tdata[17:10];
    assign in_loop = i_s_tdata[49:18];
    assign in_ts   = i_s_tdata[113:50];

    logic          accept;
    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    // slot search for start and stop
    logic          dup, has_free;
    logic [SW-1:0] free_slot, hit_idx;
    always_comb begin
        dup       = 1'b0;
        has_free  = 1'b0;
        free_slot = '0;
        hit_idx   = '0;
        for (int k = psfs_pkg::STREAM_SLOTS - 1; k >= 0; k--) begin
            if (r_active[k] && r_sl_id[k] == in_sid) begin
                dup     = 1'b1;
                hit_idx = SW'(k);
            end
            if (!r_active[k]) begin
                has_free  = 1'b1;
                free_slot = SW'(k);
            end
        end
    end

    // serial remainder step
    logic [8:0] rem_try;
    logic [8:0] rem_sub;
    assign rem_try = {r_rem, r_dvd[31]};
    assign rem_sub = rem_try - {1'b0, r_sl_div[r_slot]};

    // queue RAM banks
    logic                          ram_we0, ram_we1;
    logic [PW-1:0]                 ram_waddr, ram_raddr;
    logic [psfs_pkg::ENTRY_W-1:0]  ram_wdata, rdata0, rdata1, rdata;
    logic                          push_we, cmp_we;

    assign rdata   = r_bank ? rdata1 : rdata0;
    assign push_we = (r_state == S_TK_PUSH);
    assign cmp_we  = (r_state == S_CMP_WR) && (rdata[7:0] != r_sid);
    assign ram_we0 = (push_we && !r_bank) || (cmp_we && r_bank);
    assign ram_we1 = (push_we && r_bank) || (cmp_we && !r_bank);
    assign ram_waddr = push_we ? r_head : r_kept[PW-1:0];
    assign ram_wdata = push_we ? {r_ts, r_sl_seq[r_slot], r_sl_id[r_slot]} : rdata;
    assign ram_raddr = (r_state == S_CMP_RD) ? r_rd : r_tail;

    psfs_ram #(.WIDTH(psfs_pkg::ENTRY_W), .DEPTH(psfs_pkg::QUEUE_DEPTH)) u_bank0 (
        .i_clk(i_clk), .i_we(ram_we0), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(rdata0)
    );
    psfs_ram #(.WIDTH(psfs_pkg::ENTRY_W), .DEPTH(psfs_pkg::QUEUE_DEPTH)) u_bank1 (
        .i_clk(i_clk), .i_we(ram_we1), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(rdata1)
    );

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        if (p == PW'(psfs_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_bank   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < psfs_pkg::STREAM_SLOTS; k++) begin
                r_active[k] <= 1'b0;
            end
        end else begin
            if (i_m_tready && r_state != S_FIN) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_sid     <= in_sid;
                        r_loop    <= in_loop;
                        r_ts      <= in_ts;
                        r_fstream <= '0;
                        r_fseq    <= '0;
                        r_ftime   <= '0;
                        r_added   <= '0;
                        unique case (psfs_pkg::t_mode'(in_mode))
                            psfs_pkg::MODE_START: begin
                                r_state <= S_FIN;
                                if (in_div == 8'd0) begin
                                    r_status <= psfs_pkg::ST_BAD_DIV;
                                end else if (dup) begin
                                    r_status <= psfs_pkg::ST_DUP_ID;
                                end else if (!has_free) begin
                                    r_status <= psfs_pkg::ST_FULL;
                                end else begin
                                    r_status <= psfs_pkg::ST_OK;
                                    r_active[free_slot] <= 1'b1;
                                    r_sl_id[free_slot]  <= in_sid;
                                    r_sl_div[free_slot] <= in_div;
                                    r_sl_due[free_slot] <= in_loop + 32'(in_div);
                                    r_sl_seq[free_slot] <= '0;
                                end
                            end
                            psfs_pkg::MODE_STOP: begin
                                if (dup) begin
                                    r_active[hit_idx] <= 1'b0;
                                    r_status <= psfs_pkg::ST_OK;
                                    r_rd     <= r_tail;
                                    r_i      <= '0;
                                    r_kept   <= '0;
                                    r_state  <= S_CMP_RD;
                                end else begin
                                    r_status <= psfs_pkg::ST_NOT_FND;
                                    r_state  <= S_FIN;
                                end
                            end
                            psfs_pkg::MODE_TICK: begin
                                r_status <= psfs_pkg::ST_OK;
                                r_slot   <= '0;
                                r_state  <= S_TK_CHK;
                            end
                            psfs_pkg::MODE_DEQ: begin
                                if (r_count == '0) begin
                                    r_status <= psfs_pkg::ST_Q_EMPTY;
                                    r_state  <= S_FIN;
                                end else begin
                                    r_status <= psfs_pkg::ST_OK;
                                    r_state  <= S_DQ_WAIT;
                                end
                            end
                            default: begin
                                r_status <= psfs_pkg::ST_OK;
                                r_state  <= S_FIN;
                            end
                        endcase
                    end
                end
                S_CMP_RD: begin
                    if (r_i == r_count) begin
                        r_bank  <= !r_bank;
                        r_tail  <= '0;
                        r_count <= r_kept;
                        r_head  <= (r_kept == CW'(psfs_pkg::QUEUE_DEPTH)) ? '0
                                                                          : r_kept[PW-1:0];
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_CMP_WR;
                    end
                end
                S_CMP_WR: begin
                    if (cmp_we) begin
                        r_kept <= r_kept + 1'b1;
                    end
                    r_rd    <= ptr_inc(r_rd);
                    r_i     <= r_i + 1'b1;
                    r_state <= S_CMP_RD;
                end
                S_TK_CHK: begin
                    if (r_active[r_slot] && r_loop >= r_sl_due[r_slot]) begin
                        r_dvd   <= r_loop - r_sl_due[r_slot];
                        r_rem   <= '0;
                        r_bit   <= '0;
                        r_state <= S_TK_DIV;
                    end else if (r_slot == SW'(psfs_pkg::STREAM_SLOTS - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                end
                S_TK_DIV: begin
                    r_rem <= rem_sub[8] ? rem_try[7:0] : rem_sub[7:0];
                    r_dvd <= {r_dvd[30:0], 1'b0};
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == 5'd31) begin
                        r_state <= S_TK_PUSH;
                    end
                end
                S_TK_PUSH: begin
                    r_sl_due[r_slot] <= r_loop - 32'(r_rem) + 32'(r_sl_div[r_slot]);
                    r_sl_seq[r_slot] <= r_sl_seq[r_slot] + 1'b1;
                    r_added <= r_added + 1'b1;
                    r_head  <= ptr_inc(r_head);
                    if (r_count == CW'(psfs_pkg::QUEUE_DEPTH)) begin
                        r_tail <= ptr_inc(r_tail);
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                    if (r_slot == SW'(psfs_pkg::STREAM_SLOTS - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_slot  <= r_slot + 1'b1;
                        r_state <= S_TK_CHK;
                    end
                end
                S_DQ_WAIT: begin
                    r_fstream <= rdata[7:0];
                    r_fseq    <= rdata[23:8];
                    r_ftime   <= rdata[87:24];
                    r_tail    <= ptr_inc(r_tail);
                    r_count   <= r_count - 1'b1;
                    r_state   <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {4'd0, 5'(r_count), r_added, r_ftime, r_fseq,
                                     r_fstream, r_status};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
endmodule

>>> rtl/psfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/psfs_chk.sv
// Port-level checker for the periodic stream frame scheduler, with bind.
// Uses psfs_pkg and periodic_stream_frame_scheduler_assert.svh.
`include "periodic_stream_frame_scheduler_assert.svh"

module psfs_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_tvalid,
    input logic                       o_s_tready,
    input logic                       o_m_tvalid,
    input logic                       i_m_tready,
    input logic [psfs_pkg::OUT_W-1:0] o_m_tdata
);
    `PSFS_ASSERT(a_level, i_clk, i_rst_n, o_m_tvalid |-> (o_m_tdata[99:95] <= 5'(psfs_pkg::QUEUE_DEPTH)), "queue level above depth")
    `PSFS_ASSERT(a_status, i_clk, i_rst_n, o_m_tvalid |-> (o_m_tdata[2:0] <= psfs_pkg::ST_Q_EMPTY), "status code out of range")
    `PSFS_ASSERT(a_added_ok, i_clk, i_rst_n, (o_m_tvalid && o_m_tdata[94:91] != 4'd0) |-> (o_m_tdata[2:0] == psfs_pkg::ST_OK), "frames added on failed request")
    `PSFS_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "request taken while busy")
    `PSFS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "result changed while stalled")
endmodule

bind periodic_stream_frame_scheduler psfs_chk u_psfs_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
);
